// ===== src/fkvr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the frame receiver.
`timescale 1ns / 1ps
package fkvr_pkg;

    localparam int MAX_PAIRS = 32;
    localparam int BANK_SIZE = 3 * MAX_PAIRS;
    localparam int PAIR_W    = $clog2(MAX_PAIRS + 1);
    localparam int ADDR_PW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int MEM_AW    = ADDR_PW + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int CNT_W     = 6;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] SUM_BASE   = 8'hFF;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_OK      = 2'd1,
        EV_BADSUM  = 2'd2,
        EV_TOOLONG = 2'd3
    } t_event;

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_ORIGIN  = 6'b000010,
        PH_DEST    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic take_byte;
        logic scan_start;
        logic scan_run;
        logic load_lookup;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
    } t_sts;

endpackage

// ===== src/fkvr_ctrl.sv =====
// Controller: handshake control and the idle/scan state machine.
`timescale 1ns / 1ps
module fkvr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_func,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  fkvr_pkg::t_sts i_sts,
    output fkvr_pkg::t_cmd o_cmd
);
    import fkvr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        out_free;
    logic        accept;

    // The output register can take a new result when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.take_byte   = accept && !i_func;
        o_cmd.scan_start  = accept && i_func;
        o_cmd.scan_run    = (r_state == ST_SCAN) && !i_sts.scan_end;
        o_cmd.load_lookup = (r_state == ST_SCAN) && i_sts.scan_end && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.scan_start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (o_cmd.load_lookup) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.take_byte || o_cmd.load_lookup) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/fkvr_dp.sv =====
// Datapath: frame parser, banked pair store, key scan and result register.
`timescale 1ns / 1ps
module fkvr_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fkvr_pkg::t_cmd i_cmd,
    output fkvr_pkg::t_sts o_sts,
    input  logic [7:0]     i_rx_byte,
    input  logic [7:0]     i_query_key,
    output logic [1:0]     o_frame_event,
    output logic           o_key_found,
    output logic [15:0]    o_value,
    output logic [5:0]     o_pair_count,
    output logic [7:0]     o_frame_origin,
    output logic [7:0]     o_frame_destination
);
    import fkvr_pkg::*;

    localparam logic [1:0] LANE_KEY = 2'd0;
    localparam logic [1:0] LANE_HI  = 2'd1;
    localparam logic [1:0] LANE_LO  = 2'd2;

    // Parser state.
    t_phase              r_phase, n_phase;
    logic [7:0]          r_byte_cnt, n_byte_cnt;
    logic [7:0]          r_sum, n_sum;
    logic [1:0]          r_lane, n_lane;
    logic [PAIR_W-1:0]   r_pair, n_pair;
    logic [7:0]          r_p_origin, n_p_origin;
    logic [7:0]          r_p_dest, n_p_dest;
    logic [7:0]          r_p_len, n_p_len;
    logic                r_bank, n_bank;
    logic [7:0]          r_s_origin, n_s_origin;
    logic [7:0]          r_s_dest, n_s_dest;
    logic [PAIR_W-1:0]   r_s_count, n_s_count;
    t_event              ev;
    logic                wr_en;
    logic                len_ok;
    logic [MEM_AW-1:0]   wr_addr;

    // Pair store, one memory per byte of a triple.
    logic [7:0]          r_key_mem [MEM_DEPTH];
    logic [7:0]          r_hi_mem  [MEM_DEPTH];
    logic [7:0]          r_lo_mem  [MEM_DEPTH];

    // Scan state.
    logic [PAIR_W-1:0]   r_rd_idx;
    logic                r_cmp_vld;
    logic [7:0]          r_key_q;
    logic [7:0]          r_rd_key, r_rd_hi, r_rd_lo;
    logic [MEM_AW-1:0]   rd_addr;
    logic                issue;
    logic                hit;

    assign len_ok  = r_p_len <= 8'(BANK_SIZE);
    assign wr_addr = {~r_bank, r_pair[ADDR_PW-1:0]};

    always_comb begin
        n_phase    = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_sum      = r_sum;
        n_lane     = r_lane;
        n_pair     = r_pair;
        n_p_origin = r_p_origin;
        n_p_dest   = r_p_dest;
        n_p_len    = r_p_len;
        n_bank     = r_bank;
        n_s_origin = r_s_origin;
        n_s_dest   = r_s_dest;
        n_s_count  = r_s_count;
        ev         = EV_NONE;
        wr_en      = 1'b0;
        if (i_cmd.take_byte) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == START_BYTE) n_phase = PH_ORIGIN;
                end
                PH_ORIGIN: begin
                    n_p_origin = i_rx_byte;
                    n_phase    = PH_DEST;
                end
                PH_DEST: begin
                    n_p_dest = i_rx_byte;
                    n_phase  = PH_LEN;
                end
                PH_LEN: begin
                    n_p_len    = i_rx_byte;
                    n_byte_cnt = '0;
                    n_sum      = '0;
                    n_lane     = LANE_KEY;
                    n_pair     = '0;
                    n_phase    = (i_rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    wr_en      = len_ok;
                    n_sum      = r_sum + i_rx_byte;
                    n_byte_cnt = r_byte_cnt + 8'd1;
                    // The pair counter counts completed triples, so it ends at length / 3.
                    if (r_lane == LANE_LO) begin
                        n_lane = LANE_KEY;
                        n_pair = r_pair + PAIR_W'(1);
                    end else begin
                        n_lane = r_lane + 2'd1;
                    end
                    if (n_byte_cnt >= r_p_len) n_phase = PH_CHECK;
                end
                default: begin
                    if (!len_ok) begin
                        ev = EV_TOOLONG;
                    end else if ((SUM_BASE - r_sum) == i_rx_byte) begin
                        n_bank     = ~r_bank;
                        n_s_origin = r_p_origin;
                        n_s_dest   = r_p_dest;
                        n_s_count  = r_pair;
                        ev         = EV_OK;
                    end else begin
                        ev = EV_BADSUM;
                    end
                    n_phase    = PH_HUNT;
                    n_byte_cnt = '0;
                    n_sum      = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_byte_cnt <= '0;
            r_sum      <= '0;
            r_lane     <= LANE_KEY;
            r_pair     <= '0;
            r_p_origin <= '0;
            r_p_dest   <= '0;
            r_p_len    <= '0;
            r_bank     <= 1'b0;
            r_s_origin <= '0;
            r_s_dest   <= '0;
            r_s_count  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_sum      <= n_sum;
            r_lane     <= n_lane;
            r_pair     <= n_pair;
            r_p_origin <= n_p_origin;
            r_p_dest   <= n_p_dest;
            r_p_len    <= n_p_len;
            r_bank     <= n_bank;
            r_s_origin <= n_s_origin;
            r_s_dest   <= n_s_dest;
            r_s_count  <= n_s_count;
        end
    end

    // Payload bytes go to the inactive bank, steered by their place in the triple.
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_lane == LANE_KEY)) r_key_mem[wr_addr] <= i_rx_byte;
        if (wr_en && (r_lane == LANE_HI))  r_hi_mem[wr_addr]  <= i_rx_byte;
        if (wr_en && (r_lane == LANE_LO))  r_lo_mem[wr_addr]  <= i_rx_byte;
    end

    assign rd_addr = {r_bank, r_rd_idx[ADDR_PW-1:0]};
    assign issue   = r_rd_idx < r_s_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run) begin
            r_rd_key <= r_key_mem[rd_addr];
            r_rd_hi  <= r_hi_mem[rd_addr];
            r_rd_lo  <= r_lo_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_cmp_vld <= issue;
            if (issue) r_rd_idx <= r_rd_idx + PAIR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) r_key_q <= i_query_key;
    end

    assign hit            = r_cmp_vld && (r_rd_key == r_key_q);
    // All pairs have been issued and the last one compared, or a match stopped the scan.
    assign o_sts.scan_end = hit || (r_rd_idx >= r_s_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            o_frame_event       <= ev;
            o_key_found         <= 1'b0;
            o_value             <= '0;
            o_pair_count        <= CNT_W'(n_s_count);
            o_frame_origin      <= n_s_origin;
            o_frame_destination <= n_s_dest;
        end else if (i_cmd.load_lookup) begin
            o_frame_event       <= EV_NONE;
            o_key_found         <= hit;
            o_value             <= hit ? {r_rd_hi, r_rd_lo} : 16'd0;
            o_pair_count        <= CNT_W'(r_s_count);
            o_frame_origin      <= r_s_origin;
            o_frame_destination <= r_s_dest;
        end
    end

endmodule

// ===== src/framed_key_value_receiver_top.sv =====
// Top level of the framed key-value receiver: controller, datapath and checks.
`timescale 1ns / 1ps
//  Channel   Valid         Stall         Payload
//  input     i_in_valid    o_in_stall    i_func, i_rx_byte, i_query_key
//  output    o_out_valid   i_out_stall   o_frame_event, o_key_found, o_value,
//                                        o_pair_count, o_frame_origin,
//                                        o_frame_destination
//
// A stream byte updates the parser, and its result is registered at the accepting edge.
// A lookup runs a scan that reads one stored pair per cycle; a match ends the scan
// early. Reset is synchronous and active low; the pair memories are not cleared,
// since a lookup only ever reads pairs of an accepted frame. A stalled output holds its
// transaction; the input stalls during a lookup or behind a held result.
module framed_key_value_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_query_key,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_frame_event,
    output logic        o_key_found,
    output logic [15:0] o_value,
    output logic [5:0]  o_pair_count,
    output logic [7:0]  o_frame_origin,
    output logic [7:0]  o_frame_destination
);
    import fkvr_pkg::*;

    // Commands from the controller and scan status back from the datapath.
    t_cmd cmd;
    t_sts sts;

    fkvr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fkvr_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_rx_byte           (i_rx_byte),
        .i_query_key         (i_query_key),
        .o_frame_event       (o_frame_event),
        .o_key_found         (o_key_found),
        .o_value             (o_value),
        .o_pair_count        (o_pair_count),
        .o_frame_origin      (o_frame_origin),
        .o_frame_destination (o_frame_destination)
    );

    // A lookup transaction must block the input while the scan runs.
    a_lookup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func) |=> o_in_stall)
        else $error("input taken while a lookup was still scanning");

    // Only a lookup reports a found key, and a lookup carries no frame event.
    a_found_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_found) |-> (o_frame_event == EV_NONE))
        else $error("found key reported together with a frame event");

    // A miss always reports a zero value.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_key_found) |-> (o_value == 16'd0))
        else $error("nonzero value without a found key");

    // The stored pair count never exceeds the store size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pair_count <= CNT_W'(MAX_PAIRS)))
        else $error("pair count beyond the pair store");

endmodule

// ===== tb/tb_framed_key_value_receiver_top.sv =====
// Self-checking testbench for the framed key-value receiver: directed and random traffic.
`timescale 1ns / 1ps
module tb_framed_key_value_receiver_top;
    import fkvr_pkg::*;

    localparam logic FUNC_STREAM = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;
    localparam int   DRAIN_LIMIT = 10000;
    localparam int   SETTLE_CYCLES = 50;

    typedef logic [7:0] t_byte_queue[$];

    typedef struct packed {
        t_event      ev;
        logic        found;
        logic [15:0] value;
        logic [5:0]  pairs;
        logic [7:0]  origin;
        logic [7:0]  dest;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_func = FUNC_STREAM;
    logic [7:0]  i_rx_byte = 8'h00;
    logic [7:0]  i_query_key = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_frame_event;
    logic        o_key_found;
    logic [15:0] o_value;
    logic [5:0]  o_pair_count;
    logic [7:0]  o_frame_origin;
    logic [7:0]  o_frame_destination;

    // Receiver-side copy of the block state, advanced on every accepted transaction.
    t_phase      rx_phase = PH_HUNT;
    logic [7:0]  rx_count = 8'h00;
    logic [7:0]  rx_sum = 8'h00;
    logic [7:0]  rx_origin = 8'h00;
    logic [7:0]  rx_dest = 8'h00;
    logic [7:0]  rx_length = 8'h00;
    logic [7:0]  pair_mem[2][BANK_SIZE];
    logic        live_bank = 1'b0;
    logic [7:0]  kept_origin = 8'h00;
    logic [7:0]  kept_dest = 8'h00;
    logic [5:0]  kept_pairs = 6'd0;

    t_reply      predicted_replies[$];
    int          mismatch_count = 0;
    int          useful_items = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    framed_key_value_receiver_top dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Works out the reply to one accepted transaction and queues it.
    task automatic advance_receiver(input logic f, input logic [7:0] rb, input logic [7:0] qk);
        t_reply want;
        int     i;
        want.ev    = EV_NONE;
        want.found = 1'b0;
        want.value = 16'h0000;
        if (f == FUNC_STREAM && rx_phase == PH_HUNT && rb != START_BYTE) begin
            // A dropped byte while hunting still gets a reply but adds nothing.
        end else begin
            useful_items++;
        end
        if (f == FUNC_STREAM) begin
            case (rx_phase)
                PH_HUNT: begin
                    if (rb == START_BYTE) rx_phase = PH_ORIGIN;
                end
                PH_ORIGIN: begin
                    rx_origin = rb;
                    rx_phase  = PH_DEST;
                end
                PH_DEST: begin
                    rx_dest  = rb;
                    rx_phase = PH_LEN;
                end
                PH_LEN: begin
                    rx_length = rb;
                    rx_count  = 8'h00;
                    rx_sum    = 8'h00;
                    rx_phase  = (rb == 8'h00) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (rx_length <= BANK_SIZE) pair_mem[~live_bank][rx_count] = rb;
                    rx_sum   = rx_sum + rb;
                    rx_count = rx_count + 8'd1;
                    if (rx_count >= rx_length) rx_phase = PH_CHECK;
                end
                default: begin
                    if (rx_length > BANK_SIZE) begin
                        want.ev = EV_TOOLONG;
                    end else if (SUM_BASE - rx_sum == rb) begin
                        live_bank   = ~live_bank;
                        kept_origin = rx_origin;
                        kept_dest   = rx_dest;
                        kept_pairs  = 6'(rx_length / 3);
                        want.ev     = EV_OK;
                    end else begin
                        want.ev = EV_BADSUM;
                    end
                    rx_phase = PH_HUNT;
                    rx_count = 8'h00;
                    rx_sum   = 8'h00;
                end
            endcase
        end else begin
            for (i = 0; i < int'(kept_pairs); i++) begin
                if (pair_mem[live_bank][3 * i] == qk) begin
                    want.found = 1'b1;
                    want.value = {pair_mem[live_bank][3 * i + 1], pair_mem[live_bank][3 * i + 2]};
                    break;
                end
            end
        end
        want.pairs  = kept_pairs;
        want.origin = kept_origin;
        want.dest   = kept_dest;
        predicted_replies.push_back(want);
    endtask

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    task automatic check_reply();
        t_reply want;
        if (predicted_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected result, expected none, actual event %0d",
                     $time, o_frame_event);
        end else begin
            want = predicted_replies.pop_front();
            report_field("frame_event", 16'(want.ev), 16'(o_frame_event));
            report_field("key_found", 16'(want.found), 16'(o_key_found));
            report_field("value", want.value, o_value);
            report_field("pair_count", 16'(want.pairs), 16'(o_pair_count));
            report_field("frame_origin", 16'(want.origin), 16'(o_frame_origin));
            report_field("frame_destination", 16'(want.dest), 16'(o_frame_destination));
        end
    endtask

    // Results leave a register, so a reply never completes at the edge that took its input:
    // checking before predicting at the same edge is safe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_reply();
        if (i_rst_n && i_in_valid && !o_in_stall) advance_receiver(i_func, i_rx_byte, i_query_key);
    end

    // Valid stays high from one transaction to the next unless a gap is drawn.
    task automatic send_item(input logic f, input logic [7:0] rb, input logic [7:0] qk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= f;
        i_rx_byte   <= rb;
        i_query_key <= qk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(FUNC_STREAM, b, 8'($urandom));
    endtask

    task automatic send_lookup(input logic [7:0] k);
        send_item(FUNC_LOOKUP, 8'($urandom), k);
    endtask

    task automatic send_frame(input logic [7:0] org, input logic [7:0] dst,
                              input t_byte_queue body, input bit corrupt);
        logic [7:0] chk;
        chk = SUM_BASE;
        send_byte(START_BYTE);
        send_byte(org);
        send_byte(dst);
        send_byte(8'(body.size()));
        foreach (body[i]) begin
            send_byte(body[i]);
            chk = chk - body[i];
        end
        if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Prefers keys of the frame held right now so that lookups hit often.
    function automatic logic [7:0] pick_query_key();
        if (kept_pairs != 6'd0 && $urandom_range(99) < 60)
            return pair_mem[live_bank][3 * $urandom_range(int'(kept_pairs) - 1)];
        return 8'($urandom);
    endfunction

    task automatic test_lookup_after_reset();
        send_lookup(8'h00);
    endtask

    task automatic test_basic_frame();
        t_byte_queue body;
        body = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, START_BYTE};
        send_byte(8'hFF);
        send_frame(8'h00, 8'hFF, body, 1'b0);
        send_lookup(8'h00);
        send_lookup(8'hFF);
    endtask

    task automatic test_empty_frame();
        t_byte_queue body;
        send_frame(8'h12, 8'h34, body, 1'b0);
    endtask

    task automatic test_bad_checksum();
        t_byte_queue body;
        body = {8'h01};
        send_frame(8'hAA, 8'h55, body, 1'b1);
    endtask

    task automatic test_full_frame();
        t_byte_queue body;
        int          i;
        for (i = 0; i < MAX_PAIRS; i++) begin
            body.push_back(8'(i * 8));
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
        end
        send_frame(8'($urandom), 8'($urandom), body, 1'b0);
        send_lookup(8'((MAX_PAIRS - 1) * 8));
        send_lookup(8'h81);
    endtask

    task automatic test_too_long_frame();
        t_byte_queue body;
        int          i;
        for (i = 0; i < BANK_SIZE + 1; i++) body.push_back(8'($urandom));
        send_frame(8'($urandom), 8'($urandom), body, 1'b0);
        send_lookup(pick_query_key());
    endtask

    task automatic send_random_frame();
        t_byte_queue body;
        int          len;
        int          pick;
        int          i;
        pick = $urandom_range(99);
        if (pick < 3)
            len = ($urandom_range(3) == 0) ? $urandom_range(BANK_SIZE + 1, 255)
                                           : $urandom_range(BANK_SIZE + 1, BANK_SIZE + 8);
        else if (pick < 13)
            len = ($urandom_range(1) == 0) ? BANK_SIZE : $urandom_range(31, BANK_SIZE);
        else
            len = $urandom_range(0, 30);
        for (i = 0; i < len; i++) begin
            // A small key pool makes repeated keys, so the first match is exercised.
            if (i % 3 == 0 && $urandom_range(1) == 0)
                body.push_back(8'($urandom_range(0, 7)));
            else if ($urandom_range(31) == 0)
                body.push_back(START_BYTE);
            else
                body.push_back(8'($urandom));
        end
        send_frame(8'($urandom), 8'($urandom), body, $urandom_range(99) < 15);
        repeat ($urandom_range(0, 3)) send_lookup(pick_query_key());
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        int stop_at;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = useful_items + count;
        while (useful_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_random_frame();
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 3)) send_lookup(pick_query_key());
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                // A frame cut short: whatever follows is parsed as its remainder.
                send_byte(START_BYTE);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 20)));
            end
        end
    endtask

    initial begin
        int waited;
        send_idle_pct  = 18;
        recv_stall_pct = 68;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_lookup_after_reset();
        test_basic_frame();
        test_empty_frame();
        test_bad_checksum();
        test_full_frame();
        test_too_long_frame();
        test_random_traffic(18, 68, 600);
        test_random_traffic(68, 18, 600);
        test_random_traffic(0, 0, 600);
        i_in_valid <= 1'b0;
        waited = 0;
        while (predicted_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (predicted_replies.size() != 0) begin
            mismatch_count++;
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, predicted_replies.size());
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t ns: run did not finish in time", $time);
        $display("Verification failed");
        $finish;
    end

endmodule
